/* rtl/core/evr_pkg.sv */
// ============================================================================
// evr_pkg
// Shared types and constants for the Euler X-Y-Z vertex rotation core.
// ============================================================================
`default_nettype none

package evr_pkg;

    // Coordinate and trig formats
    localparam int COORD_WIDTH    = 32;
    localparam int TRIG_WIDTH     = 16;
    localparam int TRIG_FRAC_BITS = 14;

    // Product, shifted term and two-term sum widths
    localparam int PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;
    localparam int TERM_WIDTH = PROD_WIDTH - TRIG_FRAC_BITS;
    localparam int SUM_WIDTH  = TERM_WIDTH + 1;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 3;

    // 1.0 in trig format
    localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE =
        TRIG_WIDTH'(1 << TRIG_FRAC_BITS);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [TRIG_WIDTH-1:0]  trig_t;

    // Register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_COS_X = 3'd0,
        REG_SIN_X = 3'd1,
        REG_COS_Y = 3'd2,
        REG_SIN_Y = 3'd3,
        REG_COS_Z = 3'd4,
        REG_SIN_Z = 3'd5
    } cfg_reg_t;

    // Input word
    typedef struct packed {
        coord_t in_x;
        coord_t in_y;
        coord_t in_z;
        logic   in_last;
    } s_word_t;

    // Result word
    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
        logic   out_last;
    } m_word_t;

    // Word inside the rotation chain: u, v are the rotated pair, w rides along
    typedef struct packed {
        coord_t u;
        coord_t v;
        coord_t w;
        logic   last;
    } rot_word_t;

    // Cosine and sine of one axis
    typedef struct packed {
        trig_t cos_v;
        trig_t sin_v;
    } trig_pair_t;

endpackage

`default_nettype wire

/* rtl/core/evr_rot_stage.sv */
// ============================================================================
// evr_rot_stage
// One plane rotation: u' = sat(u*c - v*s), v' = sat(u*s + v*c), each product
// floored by the trig fraction bits. Two register stages: products, then
// add and saturate.
// ============================================================================
`default_nettype none

module evr_rot_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire evr_pkg::trig_pair_t trig,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire evr_pkg::rot_word_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output evr_pkg::rot_word_t       out_word
);

    typedef logic signed [evr_pkg::PROD_WIDTH-1:0] prod_t;
    typedef logic signed [evr_pkg::TERM_WIDTH-1:0] term_t;
    typedef logic signed [evr_pkg::SUM_WIDTH-1:0]  sum_t;

    // Clamp a two-term sum to the coordinate range
    function automatic evr_pkg::coord_t sat_coord(input sum_t val);
        logic top_same;
        top_same = (val[evr_pkg::SUM_WIDTH-1:evr_pkg::COORD_WIDTH-1] == '0) ||
                   (val[evr_pkg::SUM_WIDTH-1:evr_pkg::COORD_WIDTH-1] == '1);
        if (top_same) begin
            sat_coord = val[evr_pkg::COORD_WIDTH-1:0];
        end else if (val[evr_pkg::SUM_WIDTH-1]) begin
            sat_coord = {1'b1, {(evr_pkg::COORD_WIDTH-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(evr_pkg::COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    // Product stage registers
    logic  prod_valid_reg;
    term_t uc_reg, vs_reg, us_reg, vc_reg;
    evr_pkg::coord_t w_prod_reg;
    logic  last_prod_reg;

    // Output stage registers
    logic               out_valid_reg;
    evr_pkg::rot_word_t out_word_reg;

    logic  sum_ready;
    logic  prod_ready;
    prod_t prod_uc, prod_vs, prod_us, prod_vc;
    sum_t  u_sum, v_sum;

    // Stage advance: a stage loads when empty or when its contents move on
    assign sum_ready  = !out_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || sum_ready;
    assign in_ready   = prod_ready;

    // Four signed multiplies
    assign prod_uc = in_word.u * trig.cos_v;
    assign prod_vs = in_word.v * trig.sin_v;
    assign prod_us = in_word.u * trig.sin_v;
    assign prod_vc = in_word.v * trig.cos_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= in_valid;
        end
    end

    // Floor shift is a part-select of the product
    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid) begin
            uc_reg        <= prod_uc[evr_pkg::PROD_WIDTH-1:evr_pkg::TRIG_FRAC_BITS];
            vs_reg        <= prod_vs[evr_pkg::PROD_WIDTH-1:evr_pkg::TRIG_FRAC_BITS];
            us_reg        <= prod_us[evr_pkg::PROD_WIDTH-1:evr_pkg::TRIG_FRAC_BITS];
            vc_reg        <= prod_vc[evr_pkg::PROD_WIDTH-1:evr_pkg::TRIG_FRAC_BITS];
            w_prod_reg    <= in_word.w;
            last_prod_reg <= in_word.last;
        end
    end

    // Add, subtract and saturate
    assign u_sum = {uc_reg[evr_pkg::TERM_WIDTH-1], uc_reg} -
                   {vs_reg[evr_pkg::TERM_WIDTH-1], vs_reg};
    assign v_sum = {us_reg[evr_pkg::TERM_WIDTH-1], us_reg} +
                   {vc_reg[evr_pkg::TERM_WIDTH-1], vc_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && prod_valid_reg) begin
            out_word_reg.u    <= sat_coord(u_sum);
            out_word_reg.v    <= sat_coord(v_sum);
            out_word_reg.w    <= w_prod_reg;
            out_word_reg.last <= last_prod_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

/* rtl/core/vertex_euler_rotate_xyz_core.sv */
// Path: a vertex word passes through the X, Y and Z axis stages in order.
// Throughput: one vertex word per cycle while m_ready is held high; each axis is a product register
// followed by an add/saturate register, and a full stage frees as it drains.
// Reset: aresetn synchronous, active low; clears all valid bits and loads
// cosines with 1.0 and sines with 0 (identity rotation).
// ============================================================================
// vertex_euler_rotate_xyz_core
// Rotates a Q16.16 vertex about X, then Y, then Z using Q2.14 trig registers.
// ============================================================================
`default_nettype none

module vertex_euler_rotate_xyz_core (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration write port
    input  wire logic                                   cfg_wr_en,
    input  wire logic [evr_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [evr_pkg::TRIG_WIDTH-1:0]         cfg_wdata,
    // vertex input
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire evr_pkg::s_word_t                       s_word,
    // rotated vertex output
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output evr_pkg::m_word_t                            m_word
);

    evr_pkg::trig_t cos_x_reg, sin_x_reg;
    evr_pkg::trig_t cos_y_reg, sin_y_reg;
    evr_pkg::trig_t cos_z_reg, sin_z_reg;

    evr_pkg::trig_pair_t trig_x, trig_y, trig_z;
    evr_pkg::rot_word_t  x_in_word, x_out_word;
    evr_pkg::rot_word_t  y_in_word, y_out_word;
    evr_pkg::rot_word_t  z_in_word, z_out_word;
    logic x_out_valid, x_out_ready;
    logic y_out_valid, y_out_ready;

    // Trig registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_x_reg <= evr_pkg::TRIG_ONE;
            sin_x_reg <= '0;
            cos_y_reg <= evr_pkg::TRIG_ONE;
            sin_y_reg <= '0;
            cos_z_reg <= evr_pkg::TRIG_ONE;
            sin_z_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                evr_pkg::REG_COS_X: cos_x_reg <= cfg_wdata;
                evr_pkg::REG_SIN_X: sin_x_reg <= cfg_wdata;
                evr_pkg::REG_COS_Y: cos_y_reg <= cfg_wdata;
                evr_pkg::REG_SIN_Y: sin_y_reg <= cfg_wdata;
                evr_pkg::REG_COS_Z: cos_z_reg <= cfg_wdata;
                evr_pkg::REG_SIN_Z: sin_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign trig_x = '{cos_v: cos_x_reg, sin_v: sin_x_reg};
    assign trig_y = '{cos_v: cos_y_reg, sin_v: sin_y_reg};
    assign trig_z = '{cos_v: cos_z_reg, sin_v: sin_z_reg};

    // About X: (y, z) rotate, x rides along
    assign x_in_word = '{u: s_word.in_y, v: s_word.in_z, w: s_word.in_x,
                         last: s_word.in_last};

    evr_rot_stage u_rot_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .trig      (trig_x),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (x_in_word),
        .out_valid (x_out_valid),
        .out_ready (x_out_ready),
        .out_word  (x_out_word)
    );

    // About Y: (z1, x) rotate, y1 rides along
    assign y_in_word = '{u: x_out_word.v, v: x_out_word.w, w: x_out_word.u,
                         last: x_out_word.last};

    evr_rot_stage u_rot_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .trig      (trig_y),
        .in_valid  (x_out_valid),
        .in_ready  (x_out_ready),
        .in_word   (y_in_word),
        .out_valid (y_out_valid),
        .out_ready (y_out_ready),
        .out_word  (y_out_word)
    );

    // About Z: (x2, y1) rotate, z2 rides along
    assign z_in_word = '{u: y_out_word.v, v: y_out_word.w, w: y_out_word.u,
                         last: y_out_word.last};

    evr_rot_stage u_rot_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .trig      (trig_z),
        .in_valid  (y_out_valid),
        .in_ready  (y_out_ready),
        .in_word   (z_in_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (z_out_word)
    );

    assign m_word = '{out_x: z_out_word.u, out_y: z_out_word.v,
                      out_z: z_out_word.w, out_last: z_out_word.last};

endmodule

`default_nettype wire

/* rtl/core/evr_checker.sv */
// ============================================================================
// evr_checker
// Port-level checks on the rotation core, bound to the top level.
// ============================================================================
`default_nettype none

module evr_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire evr_pkg::m_word_t                    m_word
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // Pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // An open output never backpressures the input
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is open");

    // With the output held open, an accepted word reaches the output as m_valid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_ready) ##1 m_ready ##1 m_ready ##1 m_ready
            ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("word did not reach the output in six cycles");

endmodule

bind vertex_euler_rotate_xyz_core evr_checker u_evr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_word    (m_word)
);

`default_nettype wire
